// ----- rtl/core/upd_pkg.sv -----
// Package for the URL percent decoder: result-entry type, mode codes, character constants.
// Has no dependencies. The front, queue, back and top-level modules all import it.
package upd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Number of results that one entry expands into.
  localparam logic [1:0] CNT_NONE  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'b0001,
    MODE_PERCENT = 4'b0010,
    MODE_DIGIT   = 4'b0100,
    MODE_DISCARD = 4'b1000
  } mode_t;

  // A count of one sends data with last.
  // A count of two sends a percent sign and then the terminator.
  // A count of three sends a percent sign, then data (the held byte), then the terminator.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] data;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/upd_front.sv -----
// Front end of the URL percent decoder: takes input bytes, runs the escape state
// machine and writes one result entry per request that produces output. Uses upd_pkg.
module upd_front
  import upd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_stall,
  input  queue_status_t q_status,
  output logic          push,
  output entry_t        push_entry
);

  mode_t      mode, mode_next;
  logic [7:0] held, held_next;
  logic       accept;
  logic [4:0] hi, lo;
  logic [7:0] v;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hi = hex_value(held);
    lo = hex_value(in_byte);
    if (!hi[4]) begin
      v = 8'h00;
    end else if (!lo[4]) begin
      v = {4'h0, hi[3:0]};
    end else begin
      v = {hi[3:0], lo[3:0]};
    end
  end

  always_comb begin
    mode_next  = mode;
    held_next  = held;
    push_entry = '{cnt: CNT_NONE, data: CHAR_NUL, last: 1'b0};
    unique case (mode)
      MODE_NORMAL: begin
        if (in_byte == CHAR_NUL) begin
          push_entry = '{cnt: CNT_ONE, data: CHAR_NUL, last: 1'b1};
        end else if (in_byte == CHAR_PLUS) begin
          push_entry = '{cnt: CNT_ONE, data: CHAR_SPACE, last: 1'b0};
        end else if (in_byte == CHAR_PERCENT) begin
          mode_next = MODE_PERCENT;
        end else begin
          push_entry = '{cnt: CNT_ONE, data: in_byte, last: 1'b0};
        end
      end
      MODE_PERCENT: begin
        if (in_byte == CHAR_NUL) begin
          push_entry = '{cnt: CNT_TWO, data: CHAR_NUL, last: 1'b1};
          mode_next  = MODE_NORMAL;
        end else begin
          held_next = in_byte;
          mode_next = MODE_DIGIT;
        end
      end
      MODE_DIGIT: begin
        if (in_byte == CHAR_NUL) begin
          // A truncated escape passes through literally.
          push_entry = '{cnt: CNT_THREE, data: held, last: 1'b1};
          mode_next  = MODE_NORMAL;
        end else if (v == CHAR_NUL) begin
          push_entry = '{cnt: CNT_ONE, data: CHAR_NUL, last: 1'b1};
          mode_next  = MODE_DISCARD;
        end else begin
          push_entry = '{cnt: CNT_ONE, data: v, last: 1'b0};
          mode_next  = MODE_NORMAL;
        end
      end
      MODE_DISCARD: begin
        if (in_byte == CHAR_NUL) begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase
  end

  assign push = accept && (push_entry.cnt != CNT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      held <= CHAR_NUL;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

// ----- rtl/core/upd_queue.sv -----
// Short entry queue between the front and back of the URL percent decoder.
// Register array with read and write pointers. Uses upd_pkg.
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  entry_t          mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == Full);
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/upd_back.sv -----
// Back end of the URL percent decoder: expands each queued entry into one to
// three output results and drives the output channel. Uses upd_pkg.
module upd_back
  import upd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  entry_t        head,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  entry_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       final_piece;
  logic       take;

  assign out_valid   = cur_valid;
  assign take        = cur_valid && !out_stall;
  assign final_piece = (idx == cur.cnt - 2'd1);
  assign pop         = !q_status.empty && (!cur_valid || (take && final_piece));

  always_comb begin
    if (cur.cnt == CNT_ONE) begin
      out_byte = cur.data;
      out_last = cur.last;
    end else begin
      out_last = final_piece;
      if (idx == 2'd0) begin
        out_byte = CHAR_PERCENT;
      end else if (idx == 2'd1 && cur.cnt == CNT_THREE) begin
        out_byte = cur.data;
      end else begin
        out_byte = CHAR_NUL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (final_piece) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/url_percent_decoder.sv -----
// Streaming URL form-encoded decoder, one input byte per request. Bytes may arrive
// back to back. Most bytes give one result, an escape gives one result on its last
// digit, and a truncated escape at a terminator gives two or three. The back end sends
// one result per cycle unless the output stalls, and the entry queue (QUEUE_DEPTH
// entries) absorbs those bursts. No string gives more results than it has input
// bytes, so the sustained input rate is one byte per cycle unless the output side
// stalls. The input stalls whenever the queue is full.
// A plus sign decodes to a space. A percent sign with two hex digits decodes to one byte.
// A decoded zero byte ends the string and drops the input through its terminator.
// Top level. Instantiates upd_front, upd_queue and upd_back; uses upd_pkg.
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  queue_status_t q_status;
  logic          push, pop;
  entry_t        push_entry, head;

  upd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_stall   (in_stall),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  // The front end must never write into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_status.full)
    else $error("queue written while full");

  // The back end must never read an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("queue read while empty");

  // A stalled result stays valid and unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled result changed");
`endif

endmodule
